>>> sv/fsba_pkg.sv
// ============================================================================
// fsba_pkg
// Shared types and constants of the first-come, first-served bus arbiter.
// ============================================================================
package fsba_pkg;

    // Sizes of the block.
    localparam int NUM_PORTS   = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int PORT_W      = 3;
    localparam int WORD_W      = 64;
    localparam int DELAY_W     = 16;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_CANCEL  = 2'd1,
        CMD_SEND    = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CTS   = 2'd0,
        KIND_BCAST = 2'd1,
        KIND_ERR   = 2'd2
    } t_kind;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NOT_OWNER = 2'd1,
        ERR_BUSY      = 2'd2,
        ERR_FULL      = 2'd3
    } t_err;

    // Controller states.
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SECOND = 1'b1
    } t_state;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic owner_valid;
        logic owner_match;
        logic bus_busy;
        logic q_empty;
        logic q_full;
        logic delay_last;
    } t_dp_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  accept;
        logic  push;
        logic  pop;
        logic  grant;
        logic  grant_in;
        logic  release_bus;
        logic  send;
        logic  tick;
        logic  res0_valid;
        t_kind res0_kind;
        t_err  res0_err;
        logic  res1_valid;
        logic  show_pend;
    } t_dp_cmd;

endpackage

>>> sv/fsba_ctrl.sv
// ============================================================================
// fsba_ctrl
// Controller: decodes each accepted word against the arbiter status, issues
// datapath commands and sequences a second result when one word causes two.
// ============================================================================
module fsba_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [1:0]                   i_cmd,
    input  logic [fsba_pkg::PORT_W-1:0]  i_port,
    input  fsba_pkg::t_dp_status         i_status,
    output fsba_pkg::t_dp_cmd            o_cmd,
    output logic                         o_busy
);
    import fsba_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;
    logic   port_ok;

    assign cmd     = t_cmd'(i_cmd);
    assign port_ok = (32'(i_port) < NUM_PORTS);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a second result moves the controller to ST_SECOND, then back to ST_IDLE.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.res1_valid) begin
                    n_state = ST_SECOND;
                end
            end
            ST_SECOND: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs: command decode for the word being accepted.
    always_comb begin
        o_cmd           = '0;
        o_cmd.res0_kind = KIND_CTS;
        o_cmd.res0_err  = ERR_NONE;
        o_busy          = (r_state == ST_SECOND);
        o_cmd.show_pend = (r_state == ST_SECOND);
        o_cmd.accept    = i_start && (r_state == ST_IDLE);
        if (o_cmd.accept) begin
            case (cmd)
                CMD_REQUEST: begin
                    if (port_ok) begin
                        if (i_status.q_full) begin
                            o_cmd.res0_valid = 1'b1;
                            o_cmd.res0_kind  = KIND_ERR;
                            o_cmd.res0_err   = ERR_FULL;
                        end else if (!i_status.owner_valid && !i_status.bus_busy) begin
                            // Bus is free: grant at once, via the queue if others wait.
                            o_cmd.grant      = 1'b1;
                            o_cmd.res0_valid = 1'b1;
                            o_cmd.res0_kind  = KIND_CTS;
                            if (i_status.q_empty) begin
                                o_cmd.grant_in = 1'b1;
                            end else begin
                                o_cmd.push = 1'b1;
                                o_cmd.pop  = 1'b1;
                            end
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                end
                CMD_CANCEL, CMD_SEND: begin
                    if (!i_status.owner_valid || !i_status.owner_match) begin
                        o_cmd.res0_valid = 1'b1;
                        o_cmd.res0_kind  = KIND_ERR;
                        o_cmd.res0_err   = ERR_NOT_OWNER;
                    end else if (i_status.bus_busy) begin
                        o_cmd.res0_valid = 1'b1;
                        o_cmd.res0_kind  = KIND_ERR;
                        o_cmd.res0_err   = ERR_BUSY;
                    end else if (cmd == CMD_CANCEL) begin
                        o_cmd.release_bus = 1'b1;
                        if (!i_status.q_empty) begin
                            o_cmd.pop        = 1'b1;
                            o_cmd.grant      = 1'b1;
                            o_cmd.res0_valid = 1'b1;
                            o_cmd.res0_kind  = KIND_CTS;
                        end
                    end else begin
                        o_cmd.send = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (i_status.bus_busy) begin
                        o_cmd.tick = 1'b1;
                        if (i_status.delay_last) begin
                            // Broadcast, release and hand the bus on if a port waits.
                            o_cmd.res0_valid  = 1'b1;
                            o_cmd.res0_kind   = KIND_BCAST;
                            o_cmd.release_bus = 1'b1;
                            if (!i_status.q_empty) begin
                                o_cmd.pop        = 1'b1;
                                o_cmd.grant      = 1'b1;
                                o_cmd.res1_valid = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    o_cmd.accept = 1'b1;
                end
            endcase
        end
    end

endmodule

>>> sv/fsba_dp.sv
// ============================================================================
// fsba_dp
// Datapath: request queue, bus ownership, send delay counter, held message
// and the registered result ports.
// ============================================================================
module fsba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fsba_pkg::t_dp_cmd             i_cmd,
    input  logic [fsba_pkg::PORT_W-1:0]   i_port,
    input  logic [fsba_pkg::WORD_W-1:0]   i_payload,
    input  logic                          i_cfg_we,
    input  logic [fsba_pkg::DELAY_W-1:0]  i_cfg_data,
    output fsba_pkg::t_dp_status          o_status,
    output logic                          o_strobe,
    output logic [1:0]                    o_kind,
    output logic [fsba_pkg::PORT_W-1:0]   o_dest_port,
    output logic [fsba_pkg::PORT_W-1:0]   o_src_port,
    output logic [fsba_pkg::WORD_W-1:0]   o_msg_word,
    output logic [1:0]                    o_error_code,
    output logic                          o_last
);
    import fsba_pkg::*;

    // Queue storage and pointers.
    logic [PORT_W-1:0]  r_queue [QUEUE_DEPTH];
    logic [Q_AW-1:0]    r_head;
    logic [Q_AW-1:0]    n_head;
    logic [Q_CW-1:0]    r_count;
    logic [Q_CW-1:0]    n_count;
    logic [Q_CW:0]      tail_sum;
    logic [Q_AW-1:0]    tail_idx;

    // Bus state.
    logic               r_owner_valid;
    logic [PORT_W-1:0]  r_owner_port;
    logic               r_bus_busy;
    logic [DELAY_W-1:0] r_delay_left;
    logic [WORD_W-1:0]  r_held;
    logic [DELAY_W-1:0] r_bus_delay;
    logic [PORT_W-1:0]  grant_port;

    // Result registers.
    logic               r_strobe;
    t_kind              r_kind;
    logic [PORT_W-1:0]  r_dest;
    logic [PORT_W-1:0]  r_src;
    logic [WORD_W-1:0]  r_msg;
    t_err               r_err;
    logic               r_last;
    logic [PORT_W-1:0]  r_pend_dest;

    // Tail position and port granted this cycle.
    always_comb begin
        tail_sum = {1'b0, {(Q_CW - Q_AW){1'b0}}, r_head} + {1'b0, r_count};
        if (tail_sum >= (Q_CW + 1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (Q_CW + 1)'(QUEUE_DEPTH);
        end
        tail_idx   = tail_sum[Q_AW-1:0];
        grant_port = i_cmd.grant_in ? i_port : r_queue[r_head];
    end

    // Pointer and fill count updates.
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.pop) begin
            n_head = (r_head == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_cmd.push && !i_cmd.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Queue write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_queue[tail_idx] <= i_port;
        end
    end

    // Control state of the arbiter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= '0;
            r_owner_valid <= 1'b0;
            r_owner_port  <= '0;
            r_bus_busy    <= 1'b0;
            r_delay_left  <= '0;
            r_held        <= '0;
            r_bus_delay   <= DELAY_W'(1);
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_bus_delay <= i_cfg_data;
            end
            if (i_cmd.grant) begin
                r_owner_valid <= 1'b1;
                r_owner_port  <= grant_port;
            end else if (i_cmd.release_bus) begin
                r_owner_valid <= 1'b0;
            end
            if (i_cmd.send) begin
                r_bus_busy   <= 1'b1;
                r_held       <= i_payload;
                r_delay_left <= (r_bus_delay == '0) ? DELAY_W'(1) : r_bus_delay;
            end else if (i_cmd.tick) begin
                r_delay_left <= r_delay_left - 1'b1;
                if (i_cmd.release_bus) begin
                    r_bus_busy <= 1'b0;
                end
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.show_pend || (i_cmd.accept && i_cmd.res0_valid);
        end
    end

    // Result payload: first result on accept, pending grant in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.show_pend) begin
            r_kind <= KIND_CTS;
            r_dest <= r_pend_dest;
            r_src  <= '0;
            r_msg  <= '0;
            r_err  <= ERR_NONE;
            r_last <= 1'b1;
        end else if (i_cmd.accept) begin
            r_kind      <= i_cmd.res0_kind;
            r_dest      <= (i_cmd.res0_kind == KIND_CTS) ? grant_port : '0;
            r_src       <= (i_cmd.res0_kind == KIND_BCAST) ? r_owner_port : '0;
            r_msg       <= (i_cmd.res0_kind == KIND_BCAST) ? r_held : '0;
            r_err       <= i_cmd.res0_err;
            r_last      <= !i_cmd.res1_valid;
            r_pend_dest <= grant_port;
        end
    end

    // Status towards the controller.
    assign o_status.owner_valid = r_owner_valid;
    assign o_status.owner_match = (r_owner_port == i_port);
    assign o_status.bus_busy    = r_bus_busy;
    assign o_status.q_empty     = (r_count == '0);
    assign o_status.q_full      = (r_count >= Q_CW'(QUEUE_DEPTH));
    assign o_status.delay_last  = (r_delay_left <= DELAY_W'(1));

    assign o_strobe     = r_strobe;
    assign o_kind       = r_kind;
    assign o_dest_port  = r_dest;
    assign o_src_port   = r_src;
    assign o_msg_word   = r_msg;
    assign o_error_code = r_err;
    assign o_last       = r_last;

endmodule

>>> sv/fifo_shared_bus_arbiter_core.sv
// ============================================================================
// fifo_shared_bus_arbiter_core
// Shared-bus arbiter granting the bus to ports in first-come, first-served
// order, with delayed broadcast of the owner's message word.
// ============================================================================
// Usage:
// A command word (i_cmd, i_port, i_payload) is taken at a clock edge where
// i_start is high and o_busy is low. Commands are request, cancel, send and
// one tick of time. Each result word appears on the o_ ports for exactly one
// cycle with o_strobe high; o_last marks the final result of a command.
// The first result of a command appears in the cycle after it is taken.
// Most commands cause at most one result and the next command may follow in
// the very next cycle. A tick that broadcasts and hands the bus to a waiting
// port causes two results; o_busy is then high for one cycle while the
// broadcast word is shown, and the clear-to-send word follows in the next
// cycle. The words share the single result register. The bus delay
// register is written through i_cfg_we and i_cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Reset empties the queue, frees the bus and sets the delay to one tick.
// Results cannot be held off by the receiver.
// ============================================================================
module fifo_shared_bus_arbiter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_cmd,
    input  logic [fsba_pkg::PORT_W-1:0]   i_port,
    input  logic [fsba_pkg::WORD_W-1:0]   i_payload,
    input  logic                          i_cfg_we,
    input  logic [fsba_pkg::DELAY_W-1:0]  i_cfg_data,
    output logic                          o_strobe,
    output logic [1:0]                    o_kind,
    output logic [fsba_pkg::PORT_W-1:0]   o_dest_port,
    output logic [fsba_pkg::PORT_W-1:0]   o_src_port,
    output logic [fsba_pkg::WORD_W-1:0]   o_msg_word,
    output logic [1:0]                    o_error_code,
    output logic                          o_last
);
    import fsba_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Controller.
    fsba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .i_port   (i_port),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (o_busy)
    );

    // Datapath.
    fsba_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_port       (i_port),
        .i_payload    (i_payload),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_status     (dp_status),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_dest_port  (o_dest_port),
        .o_src_port   (o_src_port),
        .o_msg_word   (o_msg_word),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule

>>> bench/fifo_shared_bus_arbiter_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for fifo_shared_bus_arbiter_core
// Drives request, cancel, send and tick words into the arbiter and keeps its
// own model of the request queue, the bus owner and the broadcast delay.
// Every result word is compared field by field with the oldest word that
// the model expects. A directed part covers the protocol errors and the
// delay register at zero and at a long setting, then random traffic follows.
// ----------------------------------------------------------------------------
module fifo_shared_bus_arbiter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsba_pkg::*;

    // Ring of awaited words; far deeper than the few that can be outstanding.
    localparam int AWAIT_DEPTH = 16;
    localparam int AWAIT_AW    = 4;

    // One result word as the arbiter presents it.
    typedef struct {
        t_kind       kind;
        logic [2:0]  dest;
        logic [2:0]  src;
        logic [63:0] msg;
        t_err        err;
        logic        last;
    } t_bus_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [1:0]          i_cmd;
    logic [PORT_W-1:0]   i_port;
    logic [WORD_W-1:0]   i_payload;
    logic                i_cfg_we;
    logic [DELAY_W-1:0]  i_cfg_data;
    logic                o_strobe;
    logic [1:0]          o_kind;
    logic [PORT_W-1:0]   o_dest_port;
    logic [PORT_W-1:0]   o_src_port;
    logic [WORD_W-1:0]   o_msg_word;
    logic [1:0]          o_error_code;
    logic                o_last;

    // Words still awaited from the arbiter, oldest at the read count.
    t_bus_word awaited_words[AWAIT_DEPTH];
    int        aw_wr = 0;
    int        aw_rd = 0;
    t_bus_word seen_word;
    int        mismatch_count = 0;
    bit        gaps_on = 1'b1;

    // Model state of the arbiter.
    logic [2:0]      arb_queue[QUEUE_DEPTH];
    logic [Q_AW-1:0] arb_head;
    int              arb_count;
    bit              arb_owner_valid;
    logic [2:0]      arb_owner;
    bit              arb_bus_busy;
    int              arb_delay_left;
    logic [63:0]     arb_held;
    logic [15:0]     arb_bus_delay;

    fifo_shared_bus_arbiter_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_port       (i_port),
        .i_payload    (i_payload),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_dest_port  (o_dest_port),
        .o_src_port   (o_src_port),
        .o_msg_word   (o_msg_word),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Absolute limit on the run.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model of the arbiter
    // ------------------------------------------------------------------

    function void arbiter_reset();
        foreach (arb_queue[i]) arb_queue[i] = 3'd0;
        arb_head        = '0;
        arb_count       = 0;
        arb_owner_valid = 1'b0;
        arb_owner       = 3'd0;
        arb_bus_busy    = 1'b0;
        arb_delay_left  = 0;
        arb_held        = 64'd0;
        arb_bus_delay   = 16'd1;
    endfunction

    // Append one word to the awaited ring.
    function void store_word(t_bus_word w);
        awaited_words[aw_wr[AWAIT_AW-1:0]] = w;
        aw_wr++;
    endfunction

    function void add_word(t_kind k, logic [2:0] d, logic [2:0] s, logic [63:0] m, t_err e);
        t_bus_word w;
        w.kind = k;
        w.dest = d;
        w.src  = s;
        w.msg  = m;
        w.err  = e;
        w.last = 1'b0;
        store_word(w);
    endfunction

    // Hand the free bus to the oldest waiting port.
    function void grant_oldest();
        logic [2:0] p;
        if (arb_owner_valid || arb_bus_busy || arb_count == 0)
            return;
        p               = arb_queue[arb_head];
        arb_head        = Q_AW'((int'(arb_head) + 1) % QUEUE_DEPTH);
        arb_count       = arb_count - 1;
        arb_owner_valid = 1'b1;
        arb_owner       = p;
        add_word(KIND_CTS, p, 3'd0, 64'd0, ERR_NONE);
    endfunction

    // Work out the words caused by one accepted command and queue them.
    function void predict_arbiter(t_cmd cmd, logic [2:0] port, logic [63:0] payload);
        int first_wr;
        int last_wr;
        first_wr = aw_wr;
        case (cmd)
            CMD_REQUEST: begin
                if (port < NUM_PORTS) begin
                    if (arb_count >= QUEUE_DEPTH) begin
                        add_word(KIND_ERR, 3'd0, 3'd0, 64'd0, ERR_FULL);
                    end else begin
                        arb_queue[Q_AW'((int'(arb_head) + arb_count) % QUEUE_DEPTH)] = port;
                        arb_count = arb_count + 1;
                        grant_oldest();
                    end
                end
            end
            CMD_CANCEL, CMD_SEND: begin
                if (!arb_owner_valid || arb_owner != port) begin
                    add_word(KIND_ERR, 3'd0, 3'd0, 64'd0, ERR_NOT_OWNER);
                end else if (arb_bus_busy) begin
                    add_word(KIND_ERR, 3'd0, 3'd0, 64'd0, ERR_BUSY);
                end else if (cmd == CMD_CANCEL) begin
                    arb_owner_valid = 1'b0;
                    grant_oldest();
                end else begin
                    arb_held       = payload;
                    arb_bus_busy   = 1'b1;
                    arb_delay_left = (arb_bus_delay == 16'd0) ? 1 : int'(arb_bus_delay);
                end
            end
            default: begin
                // A tick only matters while a message is in flight.
                if (arb_bus_busy) begin
                    if (arb_delay_left > 0)
                        arb_delay_left = arb_delay_left - 1;
                    if (arb_delay_left == 0) begin
                        add_word(KIND_BCAST, 3'd0, arb_owner, arb_held, ERR_NONE);
                        arb_bus_busy    = 1'b0;
                        arb_owner_valid = 1'b0;
                        grant_oldest();
                    end
                end
            end
        endcase
        if (aw_wr != first_wr) begin
            last_wr = aw_wr - 1;
            awaited_words[last_wr[AWAIT_AW-1:0]].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < 40)
            $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Every strobed word is compared with the oldest awaited word.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (aw_rd == aw_wr) begin
                report_mismatch("word with none awaited, kind", 64'(o_kind), 64'd0);
            end else begin
                seen_word = awaited_words[aw_rd[AWAIT_AW-1:0]];
                aw_rd++;
                check_field("kind", 64'(o_kind), 64'(seen_word.kind));
                check_field("dest_port", 64'(o_dest_port), 64'(seen_word.dest));
                check_field("src_port", 64'(o_src_port), 64'(seen_word.src));
                check_field("msg_word", o_msg_word, seen_word.msg);
                check_field("error_code", 64'(o_error_code), 64'(seen_word.err));
                check_field("last", 64'(o_last), 64'(seen_word.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one command word, optionally after a gap, and wait until taken.
    task automatic send_word(t_cmd cmd, logic [2:0] port, logic [63:0] payload);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_cmd     <= cmd;
        i_port    <= port;
        i_payload <= payload;
        do @(posedge i_clk); while (o_busy);
        predict_arbiter(cmd, port, payload);
    endtask

    // Stop sending and wait until every awaited word has arrived.
    task settle();
        i_start <= 1'b0;
        while (aw_rd != aw_wr) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the bus delay register; only called while the arbiter is idle.
    task write_delay(logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        arb_bus_delay  = value;
    endtask

    // One random command, steered by the model so that most words are legal.
    task automatic random_item(int req_pct);
        t_cmd        c;
        logic [2:0]  p;
        logic [63:0] d;
        d = {$urandom, $urandom};
        p = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 8) begin
            c = t_cmd'($urandom_range(0, 3));
        end else if ($urandom_range(0, 99) < req_pct) begin
            c = CMD_REQUEST;
        end else if (arb_bus_busy) begin
            c = ($urandom_range(0, 9) == 0) ?
                (($urandom_range(0, 1) == 1) ? CMD_SEND : CMD_CANCEL) : CMD_TICK;
            p = arb_owner;
        end else if (arb_owner_valid) begin
            c = ($urandom_range(0, 4) == 0) ? CMD_CANCEL : CMD_SEND;
            p = arb_owner;
        end else begin
            c = ($urandom_range(0, 4) == 0) ? CMD_TICK : CMD_REQUEST;
        end
        send_word(c, p, d);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Grant, errors, broadcast with hand-over, at the reset delay of one tick.
    task test_protocol_basics();
        send_word(CMD_REQUEST, 3'd0, 64'd0);
        send_word(CMD_REQUEST, 3'd7, 64'd0);
        send_word(CMD_CANCEL, 3'd7, 64'd0);
        send_word(CMD_SEND, 3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_SEND, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_SEND, 3'd0, 64'd0);
        send_word(CMD_CANCEL, 3'd0, 64'd0);
        send_word(CMD_REQUEST, 3'd3, 64'd0);
        send_word(CMD_TICK, 3'd0, 64'd0);
        send_word(CMD_CANCEL, 3'd7, 64'd0);
        send_word(CMD_SEND, 3'd3, 64'd0);
        send_word(CMD_TICK, 3'd0, 64'd0);
        send_word(CMD_TICK, 3'd0, 64'd0);
        send_word(CMD_CANCEL, 3'd1, 64'd0);
        send_word(CMD_SEND, 3'd6, 64'hA5A5_5A5A_0F0F_F0F0);
    endtask

    // A delay of zero behaves as one tick.
    task test_zero_delay();
        settle();
        write_delay(16'd0);
        send_word(CMD_REQUEST, 3'd5, 64'd0);
        send_word(CMD_SEND, 3'd5, {$urandom, $urandom});
        send_word(CMD_REQUEST, 3'd4, 64'd0);
        send_word(CMD_TICK, 3'd2, 64'd0);
        send_word(CMD_CANCEL, 3'd4, 64'd0);
    endtask

    // Long delay reaching past the low byte: one message waits out every tick
    // while further requests queue up behind the owner.
    task test_long_delay();
        int n;
        settle();
        write_delay(16'd260);
        gaps_on = 1'b0;
        n       = 0;
        send_word(CMD_REQUEST, 3'd2, 64'd0);
        send_word(CMD_SEND, arb_owner, {$urandom, $urandom});
        while (arb_bus_busy) begin
            n++;
            if (n % 64 == 0)
                send_word(CMD_REQUEST, 3'($urandom_range(0, 7)), 64'd0);
            else
                send_word(CMD_TICK, 3'($urandom_range(0, 7)), 64'd0);
        end
        gaps_on = 1'b1;
    endtask

    // Random traffic at one delay setting, with occasional full drains.
    task test_random_traffic(logic [15:0] delay, int count, int req_pct, bit gaps);
        settle();
        write_delay(delay);
        gaps_on = gaps;
        for (int i = 0; i < count; i++) begin
            if (gaps && $urandom_range(0, 99) == 0)
                settle();
            random_item(req_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_cmd      = 2'd0;
        i_port     = '0;
        i_payload  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        arbiter_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_protocol_basics();
        test_zero_delay();
        test_long_delay();
        test_random_traffic(16'd1, 120, 30, 1'b1);
        test_random_traffic(16'($urandom_range(2, 9)), 120, 30, 1'b1);
        // Heavy requesting fills the queue and provokes overflow errors.
        test_random_traffic(16'd4, 100, 70, 1'b1);
        test_random_traffic(16'd2, 80, 30, 1'b0);

        i_start <= 1'b0;
        while (aw_rd != aw_wr) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
